@@ hdl/sadc_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the serial adc conversion reader
// no dependencies

package sadc_pkg;

    localparam int CodeWidth   = 12;
    localparam int MvWidth     = 18;
    localparam int RefWidth    = 8;
    localparam int RefMvWidth  = 18;
    localparam int ProdWidth   = CodeWidth + RefMvWidth;
    localparam int CountWidth  = 5;
    localparam int CmdWidth    = 6;
    localparam int CfgIdxWidth = 1;
    localparam int CfgWidth    = 8;

    // converter kinds
    localparam logic [1:0] KIND_2CH12 = 2'd0;
    localparam logic [1:0] KIND_2CH10 = 2'd1;
    localparam logic [1:0] KIND_4CH12 = 2'd2;
    localparam logic [1:0] KIND_ALIAS = 2'd3;

    // register indexes
    localparam logic [CfgIdxWidth-1:0] REG_DEVICE_KIND     = 1'd0;
    localparam logic [CfgIdxWidth-1:0] REG_REFERENCE_VOLTS = 1'd1;

    // action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    localparam logic [RefWidth-1:0]   REF_RESET    = 8'd5;
    localparam logic [RefMvWidth-1:0] MV_PER_VOLT  = 18'd1000;
    localparam logic [RefMvWidth-1:0] REF_MV_RESET = 18'd5000;

    // command templates
    localparam logic [4:0] CMD_HEAD_4CH = 5'h18;
    localparam logic [2:0] CMD_HEAD_2CH = 3'h6;
    localparam logic       CMD_TAIL_2CH = 1'b1;

    typedef struct packed {
        logic       action;
        logic [2:0] channel_bits;
        logic       miso_bit;
    } sadc_in_t;

    typedef struct packed {
        logic                 chip_select_n;
        logic                 clock_pulse;
        logic                 mosi_bit;
        logic                 done_res;
        logic [CodeWidth-1:0] raw_code;
        logic [MvWidth-1:0]   millivolts;
    } sadc_out_t;

    // controller to datapath
    typedef struct packed {
        logic step;
        logic load_item;
        logic load_calc;
    } sadc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic finishing;
    } sadc_stat_t;

endpackage

@@ hdl/sadc_ctrl.sv @@
`timescale 1ns / 1ps
// handshake controller for the serial adc conversion reader
// depends on sadc_pkg

module sadc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    output logic                res_valid,
    input  logic                res_stall,
    input  sadc_pkg::sadc_stat_t stat,
    output sadc_pkg::sadc_cmd_t  ctl
);
    import sadc_pkg::*;

    typedef enum logic [0:0] {
        S_RUN,
        S_CALC
    } state_t;

    state_t state_reg;
    logic   res_valid_reg;
    logic   in_take;
    logic   out_take;

    assign out_take  = res_valid_reg & ~res_stall;
    assign cmd_stall = (state_reg != S_RUN) | (res_valid_reg & res_stall);
    assign in_take   = cmd_valid & ~cmd_stall;
    assign res_valid = res_valid_reg;

    assign ctl.step      = in_take;
    assign ctl.load_item = in_take & ~stat.finishing;
    assign ctl.load_calc = (state_reg == S_CALC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_RUN:
                begin
                    if (in_take && stat.finishing)
                    begin
                        state_reg     <= S_CALC;
                        res_valid_reg <= 1'b0;
                    end
                    else if (in_take)
                    begin
                        res_valid_reg <= 1'b1;
                    end
                    else if (out_take)
                    begin
                        res_valid_reg <= 1'b0;
                    end
                end
                S_CALC:
                begin
                    state_reg     <= S_RUN;
                    res_valid_reg <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_RUN;
                end
            endcase
        end
    end

endmodule

@@ hdl/sadc_datapath.sv @@
`timescale 1ns / 1ps
// shift registers, bit counter, scaling multiplier and result register
// depends on sadc_pkg

module sadc_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  sadc_pkg::sadc_in_t                  beat,
    input  logic                                cfg_we,
    input  logic [sadc_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [sadc_pkg::CfgWidth-1:0]       cfg_data,
    input  sadc_pkg::sadc_cmd_t                 ctl,
    output sadc_pkg::sadc_stat_t                stat,
    output sadc_pkg::sadc_out_t                 result
);
    import sadc_pkg::*;

    logic                  busy_reg, busy_next;
    logic [CountWidth-1:0] bit_count_reg, bit_count_next;
    logic [CmdWidth-1:0]   command_shift_reg, command_shift_next;
    logic [CodeWidth-1:0]  reply_shift_reg, reply_shift_next;
    logic [1:0]            kind_reg, kind_next;
    logic [1:0]            device_kind_reg;
    logic [RefMvWidth-1:0] ref_mv_reg;
    logic [ProdWidth-1:0]  product_reg;
    sadc_out_t             result_reg;

    sadc_out_t             item_res;
    logic                  finishing;
    logic [1:0]            start_kind;
    logic [CountWidth-1:0] cmd_len;
    logic [CountWidth-1:0] total_len;
    logic [CountWidth-1:0] count_inc;
    logic [MvWidth-1:0]    mv_scaled;

    assign start_kind = (device_kind_reg == KIND_ALIAS) ? KIND_2CH12 : device_kind_reg;

    always_comb
    begin
        unique case (kind_reg)
            KIND_4CH12:
            begin
                cmd_len   = 5'd6;
                total_len = 5'd18;
            end
            KIND_2CH10:
            begin
                cmd_len   = 5'd4;
                total_len = 5'd14;
            end
            default:
            begin
                cmd_len   = 5'd4;
                total_len = 5'd16;
            end
        endcase
    end

    assign count_inc = bit_count_reg + 5'd1;

    always_comb
    begin
        busy_next          = busy_reg;
        bit_count_next     = bit_count_reg;
        command_shift_next = command_shift_reg;
        reply_shift_next   = reply_shift_reg;
        kind_next          = kind_reg;
        finishing          = 1'b0;
        item_res           = '0;
        item_res.chip_select_n = 1'b1;
        if (beat.action == ACT_START)
        begin
            item_res.chip_select_n = 1'b0;
            if (!busy_reg)
            begin
                kind_next = start_kind;
                if (start_kind == KIND_4CH12)
                    command_shift_next = {CMD_HEAD_4CH | {2'b00, beat.channel_bits}, 1'b0};
                else
                    command_shift_next = {2'b00, CMD_HEAD_2CH[2:1], beat.channel_bits[0],
                                          CMD_TAIL_2CH};
                reply_shift_next = '0;
                bit_count_next   = '0;
                busy_next        = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            item_res.chip_select_n = 1'b0;
            item_res.clock_pulse   = 1'b1;
            if (bit_count_reg < cmd_len)
            begin
                item_res.mosi_bit  = (kind_reg == KIND_4CH12) ? command_shift_reg[5]
                                                              : command_shift_reg[3];
                command_shift_next = {command_shift_reg[CmdWidth-2:0], 1'b0};
            end
            else
            begin
                reply_shift_next = {reply_shift_reg[CodeWidth-2:0], beat.miso_bit};
            end
            if (count_inc >= total_len)
            begin
                busy_next      = 1'b0;
                bit_count_next = '0;
                finishing      = 1'b1;
            end
            else
            begin
                bit_count_next = count_inc;
            end
        end
    end

    assign stat.finishing = finishing;

    // full scale is a power of two, so the divide is a shift
    assign mv_scaled = (kind_reg == KIND_2CH10) ? product_reg[27:10] : product_reg[29:12];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg          <= 1'b0;
            bit_count_reg     <= '0;
            command_shift_reg <= '0;
            reply_shift_reg   <= '0;
            kind_reg          <= KIND_2CH12;
            device_kind_reg   <= KIND_2CH12;
            ref_mv_reg        <= REF_MV_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DEVICE_KIND:     device_kind_reg <= cfg_data[1:0];
                    REG_REFERENCE_VOLTS: ref_mv_reg <= 18'(cfg_data * MV_PER_VOLT);
                    default:             ;
                endcase
            end
            if (ctl.step)
            begin
                busy_reg          <= busy_next;
                bit_count_reg     <= bit_count_next;
                command_shift_reg <= command_shift_next;
                reply_shift_reg   <= reply_shift_next;
                kind_reg          <= kind_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step && finishing)
            product_reg <= reply_shift_next * ref_mv_reg;
        if (ctl.load_item)
            result_reg <= item_res;
        else if (ctl.load_calc)
        begin
            result_reg.chip_select_n <= 1'b1;
            result_reg.clock_pulse   <= 1'b1;
            result_reg.mosi_bit      <= 1'b0;
            result_reg.done_res      <= 1'b1;
            result_reg.raw_code      <= reply_shift_reg;
            result_reg.millivolts    <= mv_scaled;
        end
    end

    assign result = result_reg;

endmodule

@@ hdl/spi_adc_conversion_reader_core.sv @@
`timescale 1ns / 1ps
// top level of the serial adc conversion reader
// depends on sadc_pkg, sadc_ctrl and sadc_datapath

// Serial ADC read controller stepped one serial clock period per input beat.
// A start beat latches the channel bits and the converter kind and lowers chip
// select; each tick beat then drives one command bit (msb first) or samples one
// reply bit. Every input beat yields exactly one result beat. Start, idle tick
// and ordinary tick beats can follow back to back. The tick that completes a
// conversion is followed by a calculate state: the code is multiplied by the
// reference in millivolts into a product register, then the scaled value is
// loaded into the result register, and input is stalled during that state. A
// result waiting in the output register does not block the next input beat
// unless it is still stalled when that beat would need the register.
// Configuration writes (index 0 device kind, index 1 reference volts) must
// happen only while idle; no clearing pass follows reset.

module spi_adc_conversion_reader_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  sadc_pkg::sadc_in_t               cmd_beat,
    output logic                             res_valid,
    input  logic                             res_stall,
    output sadc_pkg::sadc_out_t              res_beat,
    input  logic                             cfg_we,
    input  logic [sadc_pkg::CfgIdxWidth-1:0] cfg_index,
    input  logic [sadc_pkg::CfgWidth-1:0]    cfg_data
);
    import sadc_pkg::*;

    // command and status between controller and datapath
    sadc_cmd_t  ctl;
    sadc_stat_t stat;

    // handshake and sequencing
    sadc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    // conversion state, scaling and result register
    sadc_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (cmd_beat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .stat      (stat),
        .result    (res_beat)
    );

endmodule

@@ test/sadc_conversion_checker.sv @@
`timescale 1ns / 1ps
// conversion checker for the serial adc conversion reader: predicts each result beat
// from the accepted input beats and register writes, and compares field by field
// depends on sadc_pkg

module sadc_conversion_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    input  logic                             cmd_stall,
    input  sadc_pkg::sadc_in_t               cmd_beat,
    input  logic                             res_valid,
    input  logic                             res_stall,
    input  sadc_pkg::sadc_out_t              res_beat,
    input  logic                             cfg_we,
    input  logic [sadc_pkg::CfgIdxWidth-1:0] cfg_index,
    input  logic [sadc_pkg::CfgWidth-1:0]    cfg_data,
    output int                               fail_count,
    output int                               results_outstanding,
    output logic                             converting
);

    import sadc_pkg::*;

    localparam int unsigned FULL_SCALE_12 = 4096;
    localparam int unsigned FULL_SCALE_10 = 1024;

    // register copies
    logic [1:0]          cfg_kind;
    logic [RefWidth-1:0] cfg_ref;

    // conversion state
    logic                 busy;
    logic [1:0]           active_kind;
    logic [4:0]           bit_count;
    logic [CmdWidth-1:0]  command_sr;
    logic [CodeWidth-1:0] reply_sr;

    sadc_out_t expected_results [$];
    sadc_out_t predicted;
    sadc_out_t wanted;

    assign converting = busy;

    task automatic advance_conversion(input sadc_in_t beat, output sadc_out_t res);
        int unsigned cmd_len;
        int unsigned reply_len;
        int unsigned scale;
        int unsigned product;
        begin
            res = '0;
            res.chip_select_n = 1'b1;
            if (beat.action == ACT_START)
            begin
                // a start while busy leaves the conversion untouched
                if (!busy)
                begin
                    active_kind = (cfg_kind == KIND_ALIAS) ? KIND_2CH12 : cfg_kind;
                    if (active_kind == KIND_4CH12)
                        command_sr = {CMD_HEAD_4CH[4:3], beat.channel_bits, 1'b0};
                    else
                        command_sr = {2'b00, CMD_HEAD_2CH[2:1], beat.channel_bits[0],
                                      CMD_TAIL_2CH};
                    reply_sr  = '0;
                    bit_count = '0;
                    busy      = 1'b1;
                end
                res.chip_select_n = 1'b0;
            end
            else if (busy)
            begin
                cmd_len   = (active_kind == KIND_4CH12) ? 6 : 4;
                reply_len = (active_kind == KIND_2CH10) ? 10 : 12;
                scale     = (active_kind == KIND_2CH10) ? FULL_SCALE_10 : FULL_SCALE_12;
                res.clock_pulse   = 1'b1;
                res.chip_select_n = 1'b0;
                if (bit_count < cmd_len)
                begin
                    res.mosi_bit = command_sr[cmd_len-1];
                    command_sr   = command_sr << 1;
                end
                else
                    reply_sr = {reply_sr[CodeWidth-2:0], beat.miso_bit};
                bit_count = bit_count + 5'd1;
                if (bit_count >= cmd_len + reply_len)
                begin
                    busy              = 1'b0;
                    bit_count         = '0;
                    res.chip_select_n = 1'b1;
                    res.done_res      = 1'b1;
                    res.raw_code      = reply_sr;
                    product = 32'(reply_sr) * 32'(MV_PER_VOLT) * 32'(cfg_ref);
                    res.millivolts    = MvWidth'(product / scale);
                end
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        begin
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            cfg_kind            = KIND_2CH12;
            cfg_ref             = REF_RESET;
            busy                = 1'b0;
            active_kind         = KIND_2CH12;
            bit_count           = '0;
            command_sr          = '0;
            reply_sr            = '0;
            fail_count          = 0;
            results_outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_DEVICE_KIND)
                    cfg_kind = cfg_data[1:0];
                else
                    cfg_ref = cfg_data;
            end
            if (cmd_valid && !cmd_stall)
            begin
                advance_conversion(cmd_beat, predicted);
                expected_results.push_back(predicted);
            end
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, res_beat);
                    fail_count++;
                end
                else
                begin
                    wanted = expected_results.pop_front();
                    check_field("chip_select_n", wanted.chip_select_n, res_beat.chip_select_n);
                    check_field("clock_pulse", wanted.clock_pulse, res_beat.clock_pulse);
                    check_field("mosi_bit", wanted.mosi_bit, res_beat.mosi_bit);
                    check_field("done_res", wanted.done_res, res_beat.done_res);
                    check_field("raw_code", wanted.raw_code, res_beat.raw_code);
                    check_field("millivolts", wanted.millivolts, res_beat.millivolts);
                end
            end
            results_outstanding = expected_results.size();
        end
    end

endmodule

@@ test/spi_adc_conversion_reader_core_tb.sv @@
`timescale 1ns / 1ps
// testbench top for the serial adc conversion reader: stimulus, idling and verdict
// depends on sadc_pkg, sadc_conversion_checker and spi_adc_conversion_reader_core

module spi_adc_conversion_reader_core_tb;

    import sadc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_BEATS   = 222;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 8;
    localparam int PHASES        = 6;

    logic                   clk;
    logic                   rst_n;
    logic                   cmd_valid;
    logic                   cmd_stall;
    sadc_in_t               cmd_beat;
    logic                   res_valid;
    logic                   res_stall;
    sadc_out_t              res_beat;
    logic                   cfg_we;
    logic [CfgIdxWidth-1:0] cfg_index;
    logic [CfgWidth-1:0]    cfg_data;

    int fail_count;
    int results_outstanding;
    logic converting;

    int send_idle_pct;
    int recv_idle_pct;
    int beats_sent;
    int cycle_count;

    // register settings per random phase, extremes of both registers included
    logic [1:0]          phase_kind [0:PHASES-1] = '{KIND_4CH12, KIND_2CH10, KIND_ALIAS,
                                                     KIND_2CH12, KIND_2CH10, KIND_4CH12};
    logic [RefWidth-1:0] phase_ref  [0:PHASES-1] = '{8'd255, 8'd0, 8'd128,
                                                     8'd255, 8'd255, 8'd1};

    spi_adc_conversion_reader_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_beat  (cmd_beat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sadc_conversion_checker conversion_checker
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd_valid           (cmd_valid),
        .cmd_stall           (cmd_stall),
        .cmd_beat            (cmd_beat),
        .res_valid           (res_valid),
        .res_stall           (res_stall),
        .res_beat            (res_beat),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .fail_count          (fail_count),
        .results_outstanding (results_outstanding),
        .converting          (converting)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: a hang or a lost result ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every cycle at the falling edge
    always @(negedge clk)
        res_stall <= ($urandom_range(99) < recv_idle_pct);

    function automatic sadc_in_t make_beat(input logic action, input logic [2:0] chan,
                                           input logic miso);
        sadc_in_t beat;
        begin
            beat.action       = action;
            beat.channel_bits = chan;
            beat.miso_bit     = miso;
            return beat;
        end
    endfunction

    // present one input beat, with a random gap first, and hold it until taken;
    // valid is left high on return so back-to-back beats never drop it
    task automatic send_beat(input sadc_in_t beat);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                cmd_valid <= 1'b0;
                @(negedge clk);
            end
            cmd_valid <= 1'b1;
            cmd_beat  <= beat;
            @(posedge clk);
            while (cmd_stall)
                @(posedge clk);
            @(negedge clk);
            beats_sent++;
        end
    endtask

    // bring the block to idle: finish any open conversion with ticks, then
    // hold the sender off until every expected result beat has come back
    task automatic settle();
        begin
            while (converting)
                send_beat(make_beat(ACT_TICK, 3'($urandom_range(7)), 1'($urandom_range(1))));
            cmd_valid <= 1'b0;
            while (results_outstanding != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
    endtask

    // write both registers on consecutive cycles, only ever called once idle
    task automatic apply_settings(input logic [1:0] kind, input logic [RefWidth-1:0] ref_v);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_DEVICE_KIND;
            cfg_data  <= CfgWidth'(kind);
            @(negedge clk);
            cfg_index <= REG_REFERENCE_VOLTS;
            cfg_data  <= ref_v;
            @(negedge clk);
            cfg_we    <= 1'b0;
        end
    endtask

    initial
    begin : stimulus
        int phase;
        int phase_end;
        int pick;
        int cut;
        int ticks;
        logic [RefWidth-1:0] ref_pick;

        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        cmd_beat      = '0;
        res_stall     = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_DEVICE_KIND;
        cfg_data      = '0;
        beats_sent    = 0;
        cycle_count   = 0;
        send_idle_pct = 10;
        recv_idle_pct = 76;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed: idle ticks with every field at its extremes, a start on the
        // top channel at reset settings, a start while busy, then a full-scale code
        send_beat(make_beat(ACT_TICK, 3'd7, 1'b1));
        send_beat(make_beat(ACT_TICK, 3'd0, 1'b0));
        send_beat(make_beat(ACT_START, 3'd7, 1'b0));
        send_beat(make_beat(ACT_START, 3'd0, 1'b1));
        while (converting)
            send_beat(make_beat(ACT_TICK, 3'd0, 1'b1));

        for (phase = 0; phase < PHASES; phase++)
        begin
            // sender idles lightly first, then heavily, then the channels run flat out
            case (phase / 2)
                0:
                begin
                    send_idle_pct = 10;
                    recv_idle_pct = 76;
                end
                1:
                begin
                    send_idle_pct = 76;
                    recv_idle_pct = 10;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            settle();
            apply_settings(phase_kind[phase], phase_ref[phase]);
            phase_end = beats_sent + PHASE_BEATS;

            while (beats_sent < phase_end)
            begin
                pick = $urandom_range(99);
                if (pick < 4)
                begin
                    // occasional change of setting between conversions
                    case ($urandom_range(3))
                        0:       ref_pick = 8'd0;
                        1:       ref_pick = 8'd255;
                        default: ref_pick = RefWidth'($urandom_range(255));
                    endcase
                    settle();
                    apply_settings(2'($urandom_range(3)), ref_pick);
                end
                else if (pick < 14)
                begin
                    // noise: any beat at all
                    send_beat(make_beat(1'($urandom_range(1)), 3'($urandom_range(7)),
                                        1'($urandom_range(1))));
                end
                else
                begin
                    // a conversion with random content; some are cut short so that
                    // the next start lands while busy
                    cut = (pick < 22) ? $urandom_range(1, 17) : 1000;
                    send_beat(make_beat(ACT_START, 3'($urandom_range(7)),
                                        1'($urandom_range(1))));
                    ticks = 0;
                    while (converting && ticks < cut)
                    begin
                        if ($urandom_range(99) < 4)
                            send_beat(make_beat(ACT_START, 3'($urandom_range(7)),
                                                1'($urandom_range(1))));
                        else
                            send_beat(make_beat(ACT_TICK, 3'($urandom_range(7)),
                                                1'($urandom_range(1))));
                        ticks++;
                    end
                end
            end
        end

        cmd_valid <= 1'b0;
        while (results_outstanding != 0)
            @(negedge clk);
        repeat (END_CYCLES) @(negedge clk);

        if (fail_count == 0 && results_outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
